// ===== rtl/fscd_pkg.sv =====
// shared types, codes and lookup functions for the framed stepper command decoder
`default_nettype none
package fscd_pkg;

   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;

   localparam logic [5:0] STEP_COUNT_RESET = 6'd50;
   localparam logic [5:0] STEP_COUNT_MAX   = 6'd62;

   localparam logic [2:0] FLAGS_ALL = 3'b111;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // result kinds
   localparam logic [1:0] KIND_PHASE    = 2'd0;
   localparam logic [1:0] KIND_OFF      = 2'd1;
   localparam logic [1:0] KIND_ACCEL    = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      CMD_ROT_UP   = 2'd0,
      CMD_ROT_DN   = 2'd1,
      CMD_ACCEL    = 2'd2,
      CMD_OVERFLOW = 2'd3
   } cmd_type;

   typedef enum logic {
      BACK_IDLE   = 1'b0,
      BACK_ROTATE = 1'b1
   } back_state_type;

   // command pushed by the front end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic logic [4:0] coil_pattern(input logic [1:0] phase);
      logic [4:0] pat;
      case (phase)
         2'd0: pat = 5'h0A;
         2'd1: pat = 5'h0C;
         2'd2: pat = 5'h14;
         2'd3: pat = 5'h12;
         default: pat = 5'h00;
      endcase
      return pat;
   endfunction

   function automatic logic rcw_ok(input logic [7:0] pos, input logic [7:0] b);
      logic ok;
      case (pos)
         8'd0: ok = (b == 8'h52);
         8'd1: ok = (b == 8'h43);
         8'd2: ok = (b == 8'h57);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic rccw_ok(input logic [7:0] pos, input logic [7:0] b);
      logic ok;
      case (pos)
         8'd0: ok = (b == 8'h52);
         8'd1: ok = (b == 8'h43);
         8'd2: ok = (b == 8'h43);
         8'd3: ok = (b == 8'h57);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic accel_ok(input logic [7:0] pos, input logic [7:0] b);
      logic ok;
      case (pos)
         8'd0: ok = (b == 8'h41);
         8'd1: ok = (b == 8'h43);
         8'd2: ok = (b == 8'h43);
         8'd3: ok = (b == 8'h45);
         8'd4: ok = (b == 8'h4C);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fscd_front.sv =====
// front end: frames the byte stream, tracks keyword matches and issues commands
`default_nettype none
module fscd_front #(
   parameter int MAX_TEXT_LEN = 254
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   output fscd_pkg::push_type     push
);

   localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);

   logic [LEN_W-1:0] len_ff, len_in;
   logic [2:0]       flags_ff, flags_in;
   logic [2:0]       char_ok;
   logic [7:0]       pos8;

   assign pos8    = 8'(len_ff);
   assign char_ok = {fscd_pkg::accel_ok(pos8, rx_byte),
                     fscd_pkg::rccw_ok(pos8, rx_byte),
                     fscd_pkg::rcw_ok(pos8, rx_byte)};

   always_comb begin
      len_in     = len_ff;
      flags_in   = flags_ff;
      push.valid = 1'b0;
      push.cmd   = fscd_pkg::CMD_ACCEL;
      if (accept) begin
         if (rx_byte == fscd_pkg::BYTE_STX) begin
            len_in   = '0;
            flags_in = fscd_pkg::FLAGS_ALL;
         end else if (rx_byte == fscd_pkg::BYTE_ETX) begin
            // text is left as it is, so a repeated etx repeats the command
            if (flags_ff[0] && len_ff == LEN_W'(3)) begin
               push.valid = 1'b1;
               push.cmd   = fscd_pkg::CMD_ROT_UP;
            end else if (flags_ff[1] && len_ff == LEN_W'(4)) begin
               push.valid = 1'b1;
               push.cmd   = fscd_pkg::CMD_ROT_DN;
            end else if (flags_ff[2] && len_ff == LEN_W'(5)) begin
               push.valid = 1'b1;
               push.cmd   = fscd_pkg::CMD_ACCEL;
            end
         end else if (len_ff == LEN_W'(MAX_TEXT_LEN)) begin
            len_in     = '0;
            flags_in   = fscd_pkg::FLAGS_ALL;
            push.valid = 1'b1;
            push.cmd   = fscd_pkg::CMD_OVERFLOW;
         end else begin
            len_in   = len_ff + LEN_W'(1);
            flags_in = flags_ff & char_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         flags_ff <= fscd_pkg::FLAGS_ALL;
      end else begin
         len_ff   <= len_in;
         flags_ff <= flags_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fscd_queue.sv =====
// short command queue between front end and back end
`default_nettype none
module fscd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fscd_pkg::push_type push,
   input  wire logic               pop,
   output logic                    full,
   output fscd_pkg::head_type      head
);

   localparam int AW = fscd_pkg::QUEUE_AW;
   localparam int CW = fscd_pkg::QUEUE_AW + 1;

   fscd_pkg::cmd_type                 mem_ff [fscd_pkg::QUEUE_DEPTH];
   logic [fscd_pkg::QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]                     count_ff;
   logic                              do_push, do_pop;

   assign full       = (count_ff == CW'(fscd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fscd_back.sv =====
// back end: runs queued commands and drives the registered result word
`default_nettype none
module fscd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [5:0]         step_count,
   input  wire fscd_pkg::head_type head,
   output logic                    pop,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [1:0]              out_kind,
   output logic [4:0]              out_pattern,
   output logic                    out_last
);

   fscd_pkg::back_state_type state_ff, state_in;
   logic [5:0] left_ff, left_in;
   logic       dir_up_ff, dir_up_in;
   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [4:0] pat_ff, pat_in;
   logic       last_ff, last_in;
   logic       load_ok;
   logic [5:0] steps_sat;
   logic [1:0] phase_up, phase_dn;

   assign load_ok   = !valid_ff || out_ready;
   assign steps_sat = (step_count > fscd_pkg::STEP_COUNT_MAX) ?
                      fscd_pkg::STEP_COUNT_MAX : step_count;
   assign phase_up  = phase_ff + 2'd1;
   assign phase_dn  = phase_ff - 2'd1;

   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      dir_up_in = dir_up_ff;
      phase_in  = phase_ff;
      valid_in  = valid_ff && !out_ready;
      kind_in   = kind_ff;
      pat_in    = pat_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load_ok) begin
         case (state_ff)
            fscd_pkg::BACK_IDLE: begin
               if (head.valid) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  case (head.cmd)
                     fscd_pkg::CMD_ROT_UP, fscd_pkg::CMD_ROT_DN: begin
                        dir_up_in = (head.cmd == fscd_pkg::CMD_ROT_UP);
                        phase_in  = dir_up_in ? phase_up : phase_dn;
                        kind_in   = fscd_pkg::KIND_PHASE;
                        pat_in    = fscd_pkg::coil_pattern(phase_in);
                        last_in   = 1'b0;
                        left_in   = steps_sat;
                        state_in  = fscd_pkg::BACK_ROTATE;
                     end
                     fscd_pkg::CMD_ACCEL: begin
                        kind_in = fscd_pkg::KIND_ACCEL;
                        pat_in  = '0;
                        last_in = 1'b1;
                     end
                     default: begin
                        kind_in = fscd_pkg::KIND_OVERFLOW;
                        pat_in  = '0;
                        last_in = 1'b1;
                     end
                  endcase
               end
            end
            fscd_pkg::BACK_ROTATE: begin
               valid_in = 1'b1;
               if (left_ff == '0) begin
                  kind_in  = fscd_pkg::KIND_OFF;
                  pat_in   = '0;
                  last_in  = 1'b1;
                  state_in = fscd_pkg::BACK_IDLE;
               end else begin
                  phase_in = dir_up_ff ? phase_up : phase_dn;
                  kind_in  = fscd_pkg::KIND_PHASE;
                  pat_in   = fscd_pkg::coil_pattern(phase_in);
                  last_in  = 1'b0;
                  left_in  = left_ff - 6'd1;
               end
            end
            default: begin
               state_in = fscd_pkg::BACK_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fscd_pkg::BACK_IDLE;
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      dir_up_ff <= dir_up_in;
      kind_ff   <= kind_in;
      pat_ff    <= pat_in;
      last_ff   <= last_in;
   end

   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_pattern = pat_ff;
   assign out_last    = last_ff;

endmodule
`default_nettype wire

// ===== rtl/framed_stepper_command_decoder_top.sv =====
// top level of the framed stepper command decoder
// decodes stx/etx framed text commands from a received byte stream: "RCW" and
// "RCCW" step a full-step two-coil drive step_count+1 times up or down and end
// with an all-off word, "ACCEL" gives one readout request, and text longer than
// MAX_TEXT_LEN gives an overflow error and restarts. one byte is taken per clock
// while the four-entry command queue has room; bytes that end no command push
// nothing to it. the back end sends one result word per clock while the receiver
// is ready, so a rotate command gives step_count+2 words, a step count above 62
// being taken as 62 (so at most 64), and a readout or overflow gives one; that
// back end is what sets the sustained rate
`default_nettype none
module framed_stepper_command_decoder_top #(
   parameter int MAX_TEXT_LEN = 254
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // received bytes
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   // result words
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [4:0] drive_pattern, [7:5] zero
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast,   // last word caused by one byte
   // step count register
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [5:0] csr_data     // [5:0] step_count
);

   fscd_pkg::push_type push;
   fscd_pkg::head_type head;
   logic               q_full;
   logic               pop;
   logic [5:0]         step_count_ff;
   logic [4:0]         pattern;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= fscd_pkg::STEP_COUNT_RESET;
      end else if (csr_valid) begin
         step_count_ff <= csr_data;
      end
   end

   // front end may take a byte whenever a command could be queued
   assign req_tready = !q_full;

   fscd_front #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_tvalid && req_tready),
      .rx_byte (req_tdata),
      .push    (push)
   );

   fscd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   fscd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .step_count  (step_count_ff),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_pattern (pattern),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, pattern};

endmodule
`default_nettype wire

// ===== bench/fscd_command_checker.sv =====
// result predictor and word checker for the framed stepper command decoder
`default_nettype none
module fscd_command_checker #(
   parameter int TEXT_LIMIT = 254
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic [1:0] rsp_tuser,
   input  wire logic       rsp_tlast,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [5:0] csr_data,
   output int              mismatch_count,
   output int              words_outstanding
);

   typedef struct {
      logic [1:0] kind;
      logic [4:0] pattern;
      logic       last;
   } drive_word_type;

   localparam logic [4:0] COIL_BITS [4] = '{5'h0A, 5'h0C, 5'h14, 5'h12};

   drive_word_type words_due[$];
   drive_word_type want;
   logic [5:0]  step_cfg;
   logic [7:0]  text_len;
   logic [2:0]  match_flags;
   logic [1:0]  phase;
   int          errors;

   function automatic logic keyword_letter_ok(input logic [39:0] word, input int len,
                                              input int pos, input logic [7:0] b);
      if (pos >= len) return 1'b0;
      return word[8*(len-1-pos) +: 8] == b;
   endfunction

   task automatic push_word(input logic [1:0] kind, input logic [4:0] pattern,
                            input logic last);
      drive_word_type w;
      w.kind    = kind;
      w.pattern = pattern;
      w.last    = last;
      words_due.push_back(w);
   endtask

   // one phase word per step, then the all-off word
   task automatic push_rotation(input logic upward);
      int steps;
      steps = (step_cfg > fscd_pkg::STEP_COUNT_MAX) ? int'(fscd_pkg::STEP_COUNT_MAX)
                                                     : int'(step_cfg);
      for (int i = 0; i <= steps; i++) begin
         phase = upward ? phase + 2'd1 : phase - 2'd1;
         push_word(fscd_pkg::KIND_PHASE, COIL_BITS[phase], 1'b0);
      end
      push_word(fscd_pkg::KIND_OFF, 5'd0, 1'b1);
   endtask

   task automatic decode_rx_byte(input logic [7:0] b);
      logic [2:0] flags;
      int         pos;
      flags = match_flags;
      pos   = int'(text_len);
      if (b == fscd_pkg::BYTE_STX) begin
         text_len    = 8'd0;
         match_flags = fscd_pkg::FLAGS_ALL;
      end else if (b == fscd_pkg::BYTE_ETX) begin
         if (flags[0] && pos == 3) push_rotation(1'b1);
         else if (flags[1] && pos == 4) push_rotation(1'b0);
         else if (flags[2] && pos == 5) push_word(fscd_pkg::KIND_ACCEL, 5'd0, 1'b1);
      end else begin
         if (!keyword_letter_ok("RCW", 3, pos, b)) flags[0] = 1'b0;
         if (!keyword_letter_ok("RCCW", 4, pos, b)) flags[1] = 1'b0;
         if (!keyword_letter_ok("ACCEL", 5, pos, b)) flags[2] = 1'b0;
         pos++;
         if (pos > TEXT_LIMIT) begin
            text_len    = 8'd0;
            match_flags = fscd_pkg::FLAGS_ALL;
            push_word(fscd_pkg::KIND_OVERFLOW, 5'd0, 1'b1);
         end else begin
            text_len    = pos[7:0];
            match_flags = flags;
         end
      end
   endtask

   initial begin
      mismatch_count    = 0;
      words_outstanding = 0;
      errors            = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         step_cfg    = fscd_pkg::STEP_COUNT_RESET;
         text_len    = 8'd0;
         match_flags = fscd_pkg::FLAGS_ALL;
         phase       = 2'd0;
         words_due.delete();
      end else begin
         if (csr_valid && csr_ready) step_cfg = csr_data;
         if (req_tvalid && req_tready) decode_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (words_due.size() == 0) begin
               errors++;
               $display("%0t: expected no word, got kind %0d data 'h%02h last %0b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               want = words_due.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata !== {3'b000, want.pattern} ||
                   rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: expected kind %0d data 'h%02h last %0b,",
                           $time, want.kind, {3'b000, want.pattern}, want.last,
                           " got kind %0d data 'h%02h last %0b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      mismatch_count    <= errors;
      words_outstanding <= words_due.size();
   end

endmodule
`default_nettype wire

// ===== bench/tb_framed_stepper_command_decoder_top.sv =====
// stimulus and verdict for the framed stepper command decoder
`default_nettype none
module tb_framed_stepper_command_decoder_top;

   localparam int TEXT_LIMIT    = 254;
   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES = 80;      // a full rotation is at most 64 words
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 57;      // three random phases, about 170 bytes

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_data = 6'd0;

   int mismatch_count;
   int words_outstanding;
   int cycle_count = 0;
   int bytes_sent = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;   // stimulus asks the receiver for one long hold-off
   bit hold_done = 1'b0;
   bit steady = 1'b0;         // both sides stop idling while this is set

   framed_stepper_command_decoder_top #(
      .MAX_TEXT_LEN(TEXT_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [4:0] drive_pattern, [7:5] zero
      .rsp_tuser  (rsp_tuser),    // [1:0] kind
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // [5:0] step_count
   );

   fscd_command_checker #(
      .TEXT_LIMIT(TEXT_LIMIT)
   ) watch (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("framed_stepper_command_decoder_top: mismatch");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off so that the
   // command queue fills and the byte input stalls
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES - 1;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // any byte that is neither frame marker
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == fscd_pkg::BYTE_STX || b == fscd_pkg::BYTE_ETX) b = b ^ 8'h40;
      return b;
   endfunction

   // offer one byte, with random gaps in front; valid stays high after the
   // word is taken so that back-to-back words need no extra assignment
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 20) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_frame(input string s);
      send_byte(fscd_pkg::BYTE_STX);
      send_text(s);
      send_byte(fscd_pkg::BYTE_ETX);
   endtask

   // stop offering bytes and let every predicted word come out, then allow for
   // work still going on in bytes that give no word
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // step count is only written with the block idle
   task automatic write_step_count(input logic [5:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly good commands with random keyword and repeats, some near misses,
   // some raw noise
   task automatic send_random_frame();
      int    pick;
      int    mode;
      int    n;
      string kw;
      pick = $urandom_range(99);
      case ($urandom_range(2))
         0:       kw = "RCW";
         1:       kw = "RCCW";
         default: kw = "ACCEL";
      endcase
      if (pick < 70) begin
         // an occasional missing stx leaves the old text in front
         if ($urandom_range(9) != 0) send_byte(fscd_pkg::BYTE_STX);
         send_text(kw);
         send_byte(fscd_pkg::BYTE_ETX);
         if ($urandom_range(4) == 0) send_byte(fscd_pkg::BYTE_ETX);
      end else if (pick < 85) begin
         mode = $urandom_range(2);
         n    = $urandom_range(kw.len() - 1);
         send_byte(fscd_pkg::BYTE_STX);
         case (mode)
            0: begin
               // one letter mangled
               for (int i = 0; i < kw.len(); i++) send_byte(i == n ? plain_byte() : kw[i]);
            end
            1: begin
               // keyword cut short
               for (int i = 0; i < n; i++) send_byte(kw[i]);
            end
            default: begin
               // keyword with a trailing character
               send_text(kw);
               send_byte(plain_byte());
            end
         endcase
         send_byte(fscd_pkg::BYTE_ETX);
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int phase_start;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // text before any stx, then a repeated etx repeating the readout
      send_text("ACCEL");
      send_byte(fscd_pkg::BYTE_ETX);
      send_byte(fscd_pkg::BYTE_ETX);
      // both rotations at the reset step count
      send_frame("RCW");
      send_frame("RCCW");
      // empty text and non-letter characters give nothing
      send_byte(fscd_pkg::BYTE_STX);
      send_byte(fscd_pkg::BYTE_ETX);
      send_byte(fscd_pkg::BYTE_STX);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(fscd_pkg::BYTE_ETX);

      // step count extremes, including the saturating value above the range
      write_step_count(6'd0);
      send_frame("RCW");
      send_frame("RCCW");
      write_step_count(6'd63);
      send_frame("RCW");
      write_step_count(fscd_pkg::STEP_COUNT_MAX);
      send_frame("RCCW");

      // text overflow, then a command straight after the restart
      send_byte(fscd_pkg::BYTE_STX);
      repeat (TEXT_LIMIT + 1) send_byte(plain_byte());
      send_text("RCW");
      send_byte(fscd_pkg::BYTE_ETX);

      // long receiver hold-off while rotations keep arriving
      drain();
      hold_request = 1'b1;
      send_byte(fscd_pkg::BYTE_STX);
      send_text("RCW");
      repeat (8) send_byte(fscd_pkg::BYTE_ETX);

      // random phases, mostly small step counts; the middle one runs with no idling
      for (int p = 0; p < 3; p++) begin
         write_step_count(p == 0 ? 6'($urandom_range(7)) :
                          p == 1 ? 6'($urandom_range(15)) : 6'($urandom_range(63)));
         steady      = (p == 1);
         phase_start = bytes_sent;
         while (bytes_sent < phase_start + PHASE_ITEMS) send_random_frame();
      end
      steady = 1'b0;

      drain();
      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("framed_stepper_command_decoder_top: match");
      end else begin
         $display("framed_stepper_command_decoder_top: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/fscd_pkg.sv
rtl/fscd_front.sv
rtl/fscd_queue.sv
rtl/fscd_back.sv
rtl/framed_stepper_command_decoder_top.sv
bench/fscd_command_checker.sv
bench/tb_framed_stepper_command_decoder_top.sv
